// ----- hw/rtl/ipid_pkg.sv -----
// Shared types, register indexes and constants of the incremental PID regulator.
package ipid_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned ProdWidth = 2 * DataWidth;
   localparam int unsigned FracBits  = 16;
   localparam int unsigned SumWidth  = ProdWidth + 2;
   localparam int unsigned DeltaWidth = SumWidth - FracBits;
   localparam int unsigned AccWidth  = DeltaWidth + 1;

   localparam logic signed [DataWidth-1:0] SetpointReset  = 32'sd0;
   localparam logic signed [DataWidth-1:0] CoefNowReset   = 32'sd17039;
   localparam logic signed [DataWidth-1:0] CoefPrevReset  = 32'sd5243;
   localparam logic signed [DataWidth-1:0] CoefPrev2Reset = 32'sd10486;

   localparam logic signed [DataWidth-1:0] DataMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] DataMin = {1'b1, {(DataWidth-1){1'b0}}};

   typedef enum logic [1:0] {
      CSR_SETPOINT   = 2'd0,
      CSR_COEF_NOW   = 2'd1,
      CSR_COEF_PREV  = 2'd2,
      CSR_COEF_PREV2 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] measured_value;
      logic                        start_run;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] drive_value;
      logic signed [DataWidth-1:0] error_value;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] err;
      logic signed [DataWidth-1:0] err_one;
      logic signed [DataWidth-1:0] err_two;
      logic                        start;
      logic                        clip;
   } err_type;

   typedef struct packed {
      logic signed [ProdWidth-1:0] prod_now;
      logic signed [ProdWidth-1:0] prod_prev;
      logic signed [ProdWidth-1:0] prod_prev2;
      logic signed [DataWidth-1:0] err;
      logic                        start;
      logic                        clip;
   } prod_type;

   typedef struct packed {
      logic signed [DeltaWidth-1:0] delta;
      logic signed [DataWidth-1:0]  err;
      logic                         start;
      logic                         clip;
   } delta_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] coef_now;
      logic signed [DataWidth-1:0] coef_prev;
      logic signed [DataWidth-1:0] coef_prev2;
   } coef_type;

endpackage

// ----- hw/rtl/incremental_pid_regulator.sv -----
// Top level of the incremental PID regulator: register file and pipeline.
//
// Velocity-form PID: each word on req carries a measured value y and a start
// flag; one word on rsp returns the saturated error w - y, the updated drive
// U(k) = U(k-1) + round(q0*e + q1*e1 + q2*e2), and a saturation flag. All
// values are signed Q16.16. The pipeline has five registered stages (input,
// error, products, rounded increment, result), and a new word is taken every
// cycle while rsp_ready holds; the drive feedback closes through a single add
// and clip in the last stage. Write the setpoint and coefficients through csr
// only while no word is in flight.
module incremental_pid_regulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ipid_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ipid_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  ipid_pkg::csr_index_type               csr_index,
   input  logic [ipid_pkg::DataWidth-1:0]        csr_data
);

   logic signed [ipid_pkg::DataWidth-1:0] setpoint_ff;
   ipid_pkg::coef_type                    coef_ff;
   logic                                  err_valid;
   logic                                  err_ready;
   ipid_pkg::err_type                     err_data;
   logic                                  prod_valid;
   logic                                  prod_ready;
   ipid_pkg::prod_type                    prod_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff        <= ipid_pkg::SetpointReset;
         coef_ff.coef_now   <= ipid_pkg::CoefNowReset;
         coef_ff.coef_prev  <= ipid_pkg::CoefPrevReset;
         coef_ff.coef_prev2 <= ipid_pkg::CoefPrev2Reset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ipid_pkg::CSR_SETPOINT: begin
               setpoint_ff <= csr_data;
            end
            ipid_pkg::CSR_COEF_NOW: begin
               coef_ff.coef_now <= csr_data;
            end
            ipid_pkg::CSR_COEF_PREV: begin
               coef_ff.coef_prev <= csr_data;
            end
            ipid_pkg::CSR_COEF_PREV2: begin
               coef_ff.coef_prev2 <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   ipid_err u_err (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .setpoint  (setpoint_ff),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data)
   );

   ipid_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .err_valid  (err_valid),
      .err_ready  (err_ready),
      .err_data   (err_data),
      .coef       (coef_ff),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data)
   );

   ipid_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_saturated_has_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.error_value == ipid_pkg::DataMax) ||
         (rsp_data.error_value == ipid_pkg::DataMin) ||
         (rsp_data.drive_value == ipid_pkg::DataMax) ||
         (rsp_data.drive_value == ipid_pkg::DataMin))
      else $error("saturation flag without a clipped value");
`endif

endmodule

// ----- hw/rtl/ipid_err.sv -----
// Input register, saturating error and error delay line.
module ipid_err (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ipid_pkg::req_type                       req_data,
   input  logic signed [ipid_pkg::DataWidth-1:0]   setpoint,
   output logic                                    err_valid,
   input  logic                                    err_ready,
   output ipid_pkg::err_type                       err_data
);

   logic                                  in_valid_ff;
   ipid_pkg::req_type                     in_ff;
   logic                                  err_valid_ff;
   ipid_pkg::err_type                     err_ff;
   ipid_pkg::err_type                     err_in;
   logic signed [ipid_pkg::DataWidth-1:0] dly_one_ff;
   logic signed [ipid_pkg::DataWidth-1:0] dly_two_ff;
   logic signed [ipid_pkg::DataWidth:0]   diff;
   logic                                  in_ready;
   logic                                  move;

   assign in_ready  = !err_valid_ff || err_ready;
   assign move      = in_valid_ff && in_ready;
   assign req_ready = !in_valid_ff || in_ready;

   always_comb begin
      diff = {setpoint[ipid_pkg::DataWidth-1], setpoint}
           - {in_ff.measured_value[ipid_pkg::DataWidth-1], in_ff.measured_value};
      err_in.start = in_ff.start_run;
      err_in.clip  = (diff[ipid_pkg::DataWidth] != diff[ipid_pkg::DataWidth-1]);
      if (!err_in.clip) begin
         err_in.err = diff[ipid_pkg::DataWidth-1:0];
      end else if (diff[ipid_pkg::DataWidth]) begin
         err_in.err = ipid_pkg::DataMin;
      end else begin
         err_in.err = ipid_pkg::DataMax;
      end
      err_in.err_one = in_ff.start_run ? '0 : dly_one_ff;
      err_in.err_two = in_ff.start_run ? '0 : dly_two_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (in_ready) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
         dly_one_ff   <= '0;
         dly_two_ff   <= '0;
      end else begin
         if (move) begin
            err_valid_ff <= 1'b1;
            dly_one_ff   <= err_in.err;
            dly_two_ff   <= err_in.err_one;
         end else if (err_ready) begin
            err_valid_ff <= 1'b0;
         end
      end
      if (move) begin
         err_ff <= err_in;
      end
   end

   assign err_valid = err_valid_ff;
   assign err_data  = err_ff;

`ifndef SYNTHESIS
   a_delay_tracks_error: assert property (@(posedge clock) disable iff (reset)
      move |=> (dly_one_ff == err_ff.err) && (dly_two_ff == err_ff.err_one))
      else $error("error delay line out of step with error stage");
   a_start_clears_history: assert property (@(posedge clock) disable iff (reset)
      (err_valid_ff && err_ff.start) |-> (err_ff.err_one == '0) && (err_ff.err_two == '0))
      else $error("start word carries stale error history");
`endif

endmodule

// ----- hw/rtl/ipid_mul.sv -----
// Product stage: three coefficient by error products, registered.
module ipid_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 err_valid,
   output logic                 err_ready,
   input  ipid_pkg::err_type    err_data,
   input  ipid_pkg::coef_type   coef,
   output logic                 prod_valid,
   input  logic                 prod_ready,
   output ipid_pkg::prod_type   prod_data
);

   logic               prod_valid_ff;
   ipid_pkg::prod_type prod_ff;
   ipid_pkg::prod_type prod_in;

   assign err_ready = !prod_valid_ff || prod_ready;

   always_comb begin
      prod_in.prod_now   = coef.coef_now * err_data.err;
      prod_in.prod_prev  = coef.coef_prev * err_data.err_one;
      prod_in.prod_prev2 = coef.coef_prev2 * err_data.err_two;
      prod_in.err        = err_data.err;
      prod_in.start      = err_data.start;
      prod_in.clip       = err_data.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (err_valid && err_ready) begin
         prod_valid_ff <= 1'b1;
      end else if (prod_ready) begin
         prod_valid_ff <= 1'b0;
      end
      if (err_valid && err_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod_data  = prod_ff;

endmodule

// ----- hw/rtl/ipid_acc.sv -----
// Rounding of the product sum, drive accumulator and result register.
module ipid_acc (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 prod_valid,
   output logic                 prod_ready,
   input  ipid_pkg::prod_type   prod_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ipid_pkg::rsp_type    rsp_data
);

   logic                                   dl_valid_ff;
   ipid_pkg::delta_type                    dl_ff;
   ipid_pkg::delta_type                    dl_in;
   logic                                   rsp_valid_ff;
   ipid_pkg::rsp_type                      rsp_ff;
   ipid_pkg::rsp_type                      rsp_in;
   logic signed [ipid_pkg::DataWidth-1:0]  drive_accum_ff;
   logic signed [ipid_pkg::DataWidth-1:0]  drive_base;
   logic signed [ipid_pkg::SumWidth-1:0]   sum;
   logic signed [ipid_pkg::AccWidth-1:0]   acc_sum;
   logic                                   drive_clip;
   logic                                   out_open;
   logic                                   dl_move;

   assign out_open   = !rsp_valid_ff || rsp_ready;
   assign dl_move    = dl_valid_ff && out_open;
   assign prod_ready = !dl_valid_ff || out_open;

   always_comb begin
      sum = ipid_pkg::SumWidth'(prod_data.prod_now)
          + ipid_pkg::SumWidth'(prod_data.prod_prev)
          + ipid_pkg::SumWidth'(prod_data.prod_prev2)
          + ipid_pkg::SumWidth'(1 << (ipid_pkg::FracBits - 1));
      dl_in.delta = sum[ipid_pkg::SumWidth-1:ipid_pkg::FracBits];
      dl_in.err   = prod_data.err;
      dl_in.start = prod_data.start;
      dl_in.clip  = prod_data.clip;
   end

   always_comb begin
      drive_base = dl_ff.start ? '0 : drive_accum_ff;
      acc_sum    = ipid_pkg::AccWidth'(drive_base) + ipid_pkg::AccWidth'(dl_ff.delta);
      drive_clip = (acc_sum[ipid_pkg::AccWidth-1:ipid_pkg::DataWidth-1] != '0)
                && (acc_sum[ipid_pkg::AccWidth-1:ipid_pkg::DataWidth-1] != '1);
      if (!drive_clip) begin
         rsp_in.drive_value = acc_sum[ipid_pkg::DataWidth-1:0];
      end else if (acc_sum[ipid_pkg::AccWidth-1]) begin
         rsp_in.drive_value = ipid_pkg::DataMin;
      end else begin
         rsp_in.drive_value = ipid_pkg::DataMax;
      end
      rsp_in.error_value = dl_ff.err;
      rsp_in.saturated   = dl_ff.clip || drive_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_valid_ff <= 1'b0;
      end else if (prod_valid && prod_ready) begin
         dl_valid_ff <= 1'b1;
      end else if (out_open) begin
         dl_valid_ff <= 1'b0;
      end
      if (prod_valid && prod_ready) begin
         dl_ff <= dl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         drive_accum_ff <= '0;
      end else if (dl_move) begin
         rsp_valid_ff   <= 1'b1;
         drive_accum_ff <= rsp_in.drive_value;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (dl_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accum_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(drive_accum_ff))
      else $error("drive accumulator moved while result stalled");
   a_result_matches_accum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.drive_value == drive_accum_ff))
      else $error("result drive differs from accumulator");
`endif

endmodule

// ----- dv/incremental_pid_regulator_tb.sv -----
// Self-checking testbench for the incremental PID regulator: directed table, then random runs.
module incremental_pid_regulator_tb;

   localparam int DrainCycles = 8;
   localparam int StallLimit  = 2000;
   localparam int PhaseWords  = 125;

   typedef enum logic [1:0] {
      ROW_WORD,
      ROW_CHECKED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      ipid_pkg::csr_index_type csr_idx;
      logic [31:0]             value;
      logic                    start;
      ipid_pkg::rsp_type       want;
   } plan_row_type;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   ipid_pkg::req_type       req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   ipid_pkg::rsp_type       rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   ipid_pkg::csr_index_type csr_index = ipid_pkg::CSR_SETPOINT;
   logic [31:0]             csr_data  = '0;

   logic signed [31:0] target     = ipid_pkg::SetpointReset;
   logic signed [31:0] gain_now   = ipid_pkg::CoefNowReset;
   logic signed [31:0] gain_prev  = ipid_pkg::CoefPrevReset;
   logic signed [31:0] gain_prev2 = ipid_pkg::CoefPrev2Reset;
   logic signed [31:0] acc_drive  = '0;
   logic signed [31:0] err_last   = '0;
   logic signed [31:0] err_last2  = '0;

   ipid_pkg::rsp_type pending_updates[$];
   bit      steady = 1'b0;
   int      failures = 0;
   int      words_sent = 0;
   int      results_checked = 0;
   int      clipped_results = 0;
   int      settings_loaded = 0;
   int      idle_cycles = 0;

   incremental_pid_regulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic ipid_pkg::rsp_type step_regulator(input ipid_pkg::req_type w);
      logic signed [32:0] diff;
      logic signed [31:0] err;
      logic signed [63:0] p_now;
      logic signed [63:0] p_prev;
      logic signed [63:0] p_prev2;
      logic signed [65:0] total;
      logic signed [50:0] acc;
      ipid_pkg::rsp_type  r;
      if (w.start_run) begin
         acc_drive = '0;
         err_last  = '0;
         err_last2 = '0;
      end
      r.saturated = 1'b0;
      diff = $signed({target[31], target}) -
             $signed({w.measured_value[31], w.measured_value});
      if (diff[32] != diff[31]) begin
         err = diff[32] ? ipid_pkg::DataMin : ipid_pkg::DataMax;
         r.saturated = 1'b1;
      end else begin
         err = diff[31:0];
      end
      p_now   = gain_now * err;
      p_prev  = gain_prev * err_last;
      p_prev2 = gain_prev2 * err_last2;
      // round half up, then take the Q16.16 part
      total = p_now + p_prev + p_prev2 + 66'sd32768;
      acc = acc_drive + $signed(total[65:16]);
      if (acc[50:31] != {20{acc[50]}}) begin
         acc_drive = acc[50] ? ipid_pkg::DataMin : ipid_pkg::DataMax;
         r.saturated = 1'b1;
      end else begin
         acc_drive = acc[31:0];
      end
      err_last2 = err_last;
      err_last  = err;
      r.drive_value = acc_drive;
      r.error_value = err;
      return r;
   endfunction

   function automatic plan_row_type make_row(input row_kind_type kind,
                                             input ipid_pkg::csr_index_type idx,
                                             input logic [31:0] value, input logic start,
                                             input logic [31:0] drive, input logic [31:0] err,
                                             input logic sat);
      plan_row_type row;
      row.kind = kind;
      row.csr_idx = idx;
      row.value = value;
      row.start = start;
      row.want.drive_value = drive;
      row.want.error_value = err;
      row.want.saturated = sat;
      return row;
   endfunction

   function automatic logic [31:0] pick_target();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? ipid_pkg::DataMax : ipid_pkg::DataMin;
         default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? ipid_pkg::DataMax : ipid_pkg::DataMin;
         default: return 32'($urandom_range(0, 262144)) - 32'd131072;
      endcase
   endfunction

   function automatic logic [31:0] pick_measured(input logic [31:0] sp);
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? ipid_pkg::DataMax : ipid_pkg::DataMin;
         default: return sp + 32'($urandom_range(0, 262144)) - 32'd131072;
      endcase
   endfunction

   task automatic send_word(input ipid_pkg::req_type w, input bit typed,
                            input ipid_pkg::rsp_type typed_rsp);
      ipid_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_regulator(w);
      pending_updates.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      if (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input ipid_pkg::csr_index_type idx, input logic [31:0] val,
                            input bit hold);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (!hold) csr_valid <= 1'b0;
      case (idx)
         ipid_pkg::CSR_SETPOINT:   target     = val;
         ipid_pkg::CSR_COEF_NOW:   gain_now   = val;
         ipid_pkg::CSR_COEF_PREV:  gain_prev  = val;
         ipid_pkg::CSR_COEF_PREV2: gain_prev2 = val;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin : check_results
      ipid_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            $error("drive update with no word outstanding: drive %0d error %0d",
                   rsp_data.drive_value, rsp_data.error_value);
            failures++;
         end else begin
            want = pending_updates.pop_front();
            results_checked++;
            if (want.saturated) clipped_results++;
            if (rsp_data.drive_value !== want.drive_value) begin
               $error("drive_value: expected %0d, got %0d",
                      want.drive_value, rsp_data.drive_value);
               failures++;
            end
            if (rsp_data.error_value !== want.error_value) begin
               $error("error_value: expected %0d, got %0d",
                      want.error_value, rsp_data.error_value);
               failures++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_data.saturated);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      plan_row_type      plan[$];
      plan_row_type      row;
      ipid_pkg::req_type w;
      logic [31:0]       sp;
      logic [31:0]       g0;
      logic [31:0]       g1;
      logic [31:0]       g2;
      int                run_left;

      // reset gains
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, 32'h0, 1'b1,
                              32'h0, 32'h0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'h0001_0000, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, 32'h0, 1'b1,
                              32'h0, 32'h0, 1'b0));
      // unity proportional gain: drive integrates the error
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_NOW, 32'h0001_0000, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV, 32'h0, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV2, 32'h0, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b1,
                              ipid_pkg::DataMax, ipid_pkg::DataMax, 1'b1));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b0,
                              ipid_pkg::DataMax, ipid_pkg::DataMax, 1'b1));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              32'h0, 32'h8000_0001, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              32'h8000_0001, 32'h8000_0001, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              ipid_pkg::DataMin, 32'h8000_0001, 1'b1));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b1,
                              ipid_pkg::DataMax, ipid_pkg::DataMax, 1'b1));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              ipid_pkg::DataMax, 32'h0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b1,
                              ipid_pkg::DataMin, ipid_pkg::DataMin, 1'b1));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b0,
                              ipid_pkg::DataMin, 32'h0, 1'b0));
      // extreme gains of mixed sign
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_SETPOINT, 32'h0, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_NOW, ipid_pkg::DataMin, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV, ipid_pkg::DataMax, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV2, ipid_pkg::DataMin, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMin, 1'b1,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, ipid_pkg::DataMax, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'h1234_5678, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'hFFFF_FFFF, 1'b0,
                              0, 0, 1'b0));
      // tiny gains exercise the rounding
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_NOW, 32'h1, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV, 32'hFFFF_FFFF, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV2, 32'h1, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'h8000_8000, 1'b1,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'h7FFF_8000, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_WORD, ipid_pkg::CSR_SETPOINT, 32'hFFFF_8000, 1'b0,
                              0, 0, 1'b0));
      // half gain: ties round toward plus infinity
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_NOW, 32'h0000_8000, 1'b0,
                              0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV, 32'h0, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CSR, ipid_pkg::CSR_COEF_PREV2, 32'h0, 1'b0, 0, 0, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, 32'hFFFF_FFFF, 1'b1,
                              32'h1, 32'h1, 1'b0));
      plan.push_back(make_row(ROW_CHECKED, ipid_pkg::CSR_SETPOINT, 32'h1, 1'b0,
                              32'h1, 32'hFFFF_FFFF, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            settle_pipeline();
            write_csr(row.csr_idx, row.value, 1'b0);
         end else begin
            w.measured_value = row.value;
            w.start_run = row.start;
            send_word(w, row.kind == ROW_CHECKED, row.want);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         settle_pipeline();
         case (phase)
            0: begin
               sp = ipid_pkg::DataMax;
               g0 = ipid_pkg::DataMax;
               g1 = ipid_pkg::DataMax;
               g2 = ipid_pkg::DataMax;
            end
            1: begin
               sp = ipid_pkg::DataMin;
               g0 = ipid_pkg::DataMin;
               g1 = ipid_pkg::DataMin;
               g2 = ipid_pkg::DataMin;
            end
            2: begin
               sp = pick_target();
               g0 = ipid_pkg::CoefNowReset;
               g1 = ipid_pkg::CoefPrevReset;
               g2 = ipid_pkg::CoefPrev2Reset;
            end
            default: begin
               sp = pick_target(); g0 = pick_gain(); g1 = pick_gain(); g2 = pick_gain();
            end
         endcase
         write_csr(ipid_pkg::CSR_SETPOINT, sp, 1'b1);
         write_csr(ipid_pkg::CSR_COEF_NOW, g0, 1'b1);
         write_csr(ipid_pkg::CSR_COEF_PREV, g1, 1'b1);
         write_csr(ipid_pkg::CSR_COEF_PREV2, g2, 1'b0);
         settings_loaded++;
         steady = (phase == 3);
         run_left = 0;
         for (int n = 0; n < PhaseWords; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(3, 40);
               w.start_run = 1'b1;
            end else begin
               w.start_run = ($urandom_range(99) < 3);
            end
            run_left--;
            w.measured_value = pick_measured(sp);
            if ($urandom_range(79) == 0) settle_pipeline();
            send_word(w, 1'b0, '0);
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d measurements under %0d gain settings plus the directed table.",
               words_sent, settings_loaded);
      $display("Checked %0d drive updates, %0d of them clipped.",
               results_checked, clipped_results);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
